/* hdl/singly_linked_list_with_cursor_unit_macros.svh */
// Assertion macros for the linked list unit.
// The checks compile to nothing when SYNTHESIS is defined.
`ifndef SINGLY_LINKED_LIST_WITH_CURSOR_UNIT_MACROS_SVH
`define SINGLY_LINKED_LIST_WITH_CURSOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define LLS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lls check failed");
`define LLS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lls check failed");
`else
`define LLS_ASSERT_NOW(label, clk, rst, ante, cons)
`define LLS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* hdl/lls_pkg.sv */
package lls_pkg;

  localparam int DEF_NODE_COUNT = 64;
  localparam int DEF_VALUE_BITS = 32;
  localparam int ACT_W = 4;
  localparam int WORD_W = 32;

  typedef enum logic [ACT_W-1:0] {
    ACT_CLEAR        = 4'd0,
    ACT_INS_HEAD     = 4'd1,
    ACT_CURSOR_HEAD  = 4'd2,
    ACT_READ_HEAD    = 4'd3,
    ACT_DEL_HEAD     = 4'd4,
    ACT_DEL_AFTER    = 4'd5,
    ACT_INS_AFTER    = 4'd6,
    ACT_READ_CURSOR  = 4'd7,
    ACT_WRITE_CURSOR = 4'd8,
    ACT_ADVANCE      = 4'd9
  } act_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_EXEC
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic look;
    logic exec;
  } cmd_t;

endpackage

/* hdl/lls_ctrl.sv */
`include "singly_linked_list_with_cursor_unit_macros.svh"

module lls_ctrl import lls_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output cmd_t cmd,
  output logic out_valid,
  input  logic out_stall
);

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        // The result register must be free before the item commits.
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    cmd      = '0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_LOOK: begin
        cmd.look = 1'b1;
      end
      ST_EXEC: begin
        cmd.exec = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.exec) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  `LLS_ASSERT_NEXT(a_load_to_look, clk, rst, cmd.load, state == ST_LOOK)
  `LLS_ASSERT_NEXT(a_look_to_exec, clk, rst, cmd.look, state == ST_EXEC)
  `LLS_ASSERT_NEXT(a_exec_fills_out, clk, rst, cmd.exec, out_valid && state == ST_IDLE)

endmodule

/* hdl/lls_dp.sv */
`include "singly_linked_list_with_cursor_unit_macros.svh"

module lls_dp import lls_pkg::*; #(
  parameter int NODE_COUNT = DEF_NODE_COUNT,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  cmd_t                     cmd,
  input  logic [ACT_W-1:0]         action,
  input  logic signed [WORD_W-1:0] value,
  output logic signed [WORD_W-1:0] read_value,
  output logic                     error,
  output logic                     error_seen,
  output logic                     cursor_active,
  output logic                     list_empty
);

  localparam int AW = $clog2(NODE_COUNT);
  localparam int PW = $clog2(NODE_COUNT + 1);
  localparam logic [PW-1:0] NIL = PW'(NODE_COUNT);

  typedef logic [PW-1:0] ptr_t;

  function automatic logic is_node(input ptr_t p);
    return p < NIL;
  endfunction

  // Node store: values and next links, one read and one write port each.
  logic [VALUE_BITS-1:0] val_mem [NODE_COUNT];
  ptr_t                  link_mem [NODE_COUNT];

  ptr_t                  head;
  ptr_t                  cursor;
  ptr_t                  free_head;
  ptr_t                  fresh;
  logic                  sticky;
  act_t                  act_q;
  logic signed [WORD_W-1:0] val_q;
  ptr_t                  link_hold;

  ptr_t                  head_next;
  ptr_t                  cursor_next;
  ptr_t                  free_head_next;
  ptr_t                  fresh_next;
  logic                  sticky_next;
  logic                  err;
  logic signed [WORD_W-1:0] read_next;

  act_t                  act_in;
  logic                  free_ok;
  logic                  alloc_ok;
  ptr_t                  new_node;
  logic                  cur_ok;
  logic                  head_ok;
  logic [VALUE_BITS-1:0] fit_val;

  ptr_t                  link_raddr;
  logic                  link_ren;
  ptr_t                  link_rd;
  logic                  link_we;
  ptr_t                  link_waddr;
  ptr_t                  link_wdata;
  ptr_t                  val_raddr;
  logic [VALUE_BITS-1:0] val_rd;
  logic                  val_we;
  ptr_t                  val_waddr;

  assign act_in   = act_t'(action);
  assign free_ok  = is_node(free_head);
  assign alloc_ok = free_ok || (fresh < NIL);
  assign new_node = free_ok ? free_head : fresh;
  assign cur_ok   = is_node(cursor);
  assign head_ok  = is_node(head);
  assign fit_val  = VALUE_BITS'(val_q);

  // The first link read goes out in the cycle the item is accepted; the
  // second follows that link where the action needs two hops.
  always_comb begin
    link_raddr = cursor;
    if (cmd.load) begin
      unique case (act_in) inside
        ACT_INS_HEAD, ACT_INS_AFTER: link_raddr = free_head;
        ACT_DEL_HEAD:                link_raddr = head;
        default:                     link_raddr = cursor;
      endcase
    end else if (act_q == ACT_DEL_AFTER) begin
      link_raddr = link_rd;
    end
  end

  assign link_ren  = cmd.load || cmd.look;
  assign val_raddr = (act_in == ACT_READ_HEAD) ? head : cursor;

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr[AW-1:0]] <= link_wdata;
    end
    if (link_ren) begin
      link_rd <= link_mem[link_raddr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[val_waddr[AW-1:0]] <= fit_val;
    end
    if (cmd.load) begin
      val_rd <= val_mem[val_raddr[AW-1:0]];
    end
  end

  always_comb begin
    head_next      = head;
    cursor_next    = cursor;
    free_head_next = free_head;
    fresh_next     = fresh;
    err            = 1'b0;
    read_next      = '0;
    link_we        = 1'b0;
    link_waddr     = cursor;
    link_wdata     = free_head;
    val_we         = 1'b0;
    val_waddr      = new_node;

    if (cmd.look) begin
      // Actions that rewrite two links do the first one here. The read of
      // the same entry in this cycle still returns the old link.
      unique case (act_q) inside
        ACT_DEL_AFTER: begin
          if (cur_ok && is_node(link_rd)) begin
            link_we    = 1'b1;
            link_waddr = link_rd;
            link_wdata = free_head;
          end
        end
        ACT_INS_AFTER: begin
          if (cur_ok && alloc_ok) begin
            link_we    = 1'b1;
            link_waddr = cursor;
            link_wdata = new_node;
          end
        end
        default: begin
          link_we = 1'b0;
        end
      endcase
    end

    if (cmd.exec) begin
      unique case (act_q) inside
        ACT_CLEAR: begin
          head_next      = NIL;
          cursor_next    = NIL;
          free_head_next = NIL;
          fresh_next     = '0;
        end
        ACT_INS_HEAD, ACT_INS_AFTER: begin
          if (act_q == ACT_INS_HEAD || cur_ok) begin
            if (alloc_ok) begin
              val_we     = 1'b1;
              val_waddr  = new_node;
              link_we    = 1'b1;
              link_waddr = new_node;
              if (act_q == ACT_INS_HEAD) begin
                link_wdata = head;
                head_next  = new_node;
              end else begin
                link_wdata = link_rd;
              end
              if (free_ok) begin
                free_head_next = link_hold;
              end else begin
                fresh_next = fresh + 1'b1;
              end
            end else begin
              err = 1'b1;
            end
          end
        end
        ACT_CURSOR_HEAD: begin
          cursor_next = head;
        end
        ACT_READ_HEAD: begin
          if (head_ok) begin
            read_next = WORD_W'($signed(val_rd));
          end else begin
            err = 1'b1;
          end
        end
        ACT_DEL_HEAD: begin
          if (head_ok) begin
            if (cursor == head) begin
              cursor_next = NIL;
            end
            head_next      = link_hold;
            link_we        = 1'b1;
            link_waddr     = head;
            link_wdata     = free_head;
            free_head_next = head;
          end
        end
        ACT_DEL_AFTER: begin
          if (cur_ok && is_node(link_hold)) begin
            link_we        = 1'b1;
            link_waddr     = cursor;
            link_wdata     = link_rd;
            free_head_next = link_hold;
          end
        end
        ACT_READ_CURSOR: begin
          if (cur_ok) begin
            read_next = WORD_W'($signed(val_rd));
          end else begin
            err = 1'b1;
          end
        end
        ACT_WRITE_CURSOR: begin
          if (cur_ok) begin
            val_we    = 1'b1;
            val_waddr = cursor;
          end
        end
        ACT_ADVANCE: begin
          if (cur_ok) begin
            cursor_next = link_hold;
          end
        end
        default: begin
          err = 1'b0;
        end
      endcase
    end
  end

  assign sticky_next = sticky || err;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_q <= act_in;
      val_q <= value;
    end
    if (cmd.look) begin
      link_hold <= link_rd;
    end
    if (cmd.exec) begin
      read_value    <= read_next;
      error         <= err;
      error_seen    <= sticky_next;
      cursor_active <= is_node(cursor_next);
      list_empty    <= !is_node(head_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= NIL;
      cursor    <= NIL;
      free_head <= NIL;
      fresh     <= '0;
      sticky    <= 1'b0;
    end else if (cmd.exec) begin
      head      <= head_next;
      cursor    <= cursor_next;
      free_head <= free_head_next;
      fresh     <= fresh_next;
      sticky    <= sticky_next;
    end
  end

  `LLS_ASSERT_NOW(a_cursor_on_list, clk, rst, cursor < NIL, head < NIL)
  `LLS_ASSERT_NOW(a_fresh_bound, clk, rst, 1'b1, fresh <= NIL)
  `LLS_ASSERT_NEXT(a_sticky_holds, clk, rst, sticky, sticky)

endmodule

/* hdl/singly_linked_list_with_cursor_unit.sv */
// Singly linked list of signed values held in a pool of NODE_COUNT nodes, with
// a head pointer and a cursor; each input item is one list action and gives
// exactly one result item. On its way to a loaded result register an item
// passes the accept cycle, which reads the node store, then the look state,
// which follows one more link through the single read port of the link
// memory, and then the exec state, which commits the writes and the result.
// A new item is accepted in the cycle after the commit, so the unit takes no
// new item before the last one has committed, and holds in the commit cycle
// while a finished result still waits. Clear frees the whole pool in one
// step, and the node store needs no clearing pass after reset.
module singly_linked_list_with_cursor_unit import lls_pkg::*; #(
  parameter int NODE_COUNT = DEF_NODE_COUNT,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [ACT_W-1:0]         action,
  input  logic signed [WORD_W-1:0] value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [WORD_W-1:0] read_value,
  output logic                     error,
  output logic                     error_seen,
  output logic                     cursor_active,
  output logic                     list_empty
);

  cmd_t cmd;

  lls_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_stall (out_stall)
  );

  lls_dp #(
    .NODE_COUNT (NODE_COUNT),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .action        (action),
    .value         (value),
    .read_value    (read_value),
    .error         (error),
    .error_seen    (error_seen),
    .cursor_active (cursor_active),
    .list_empty    (list_empty)
  );

endmodule
